/* rtl/rhsd_pkg.sv */
// ----------------------------------------------------------------------------
// rhsd_pkg
// Shared types, constants and helpers of the run-length hex string decoder.
// ----------------------------------------------------------------------------
package rhsd_pkg;

	// Dictionary geometry
	localparam int unsigned DICT_ENTRIES = 32;
	localparam int unsigned DICT_WORDS   = 4;
	localparam logic [5:0]  DICT_MAX     = 6'(DICT_ENTRIES);

	// Configuration register indexes
	localparam logic [2:0] CFG_DICT_BASE  = 3'd0;
	localparam logic [2:0] CFG_DICT_COUNT = 3'd1;
	localparam logic [2:0] CFG_DICT_B0    = 3'd2;
	localparam logic [2:0] CFG_DICT_B1    = 3'd3;
	localparam logic [2:0] CFG_DICT_B2    = 3'd4;
	localparam logic [2:0] CFG_DICT_B3    = 3'd5;

	localparam logic [7:0] DICT_BASE_RESET = 8'd73;

	// Run mark letters
	localparam logic [7:0] CHAR_A_LOW = 8'h61;
	localparam logic [7:0] CHAR_Z_LOW = 8'h7a;

	localparam logic [15:0] COUNT_MAX = 16'hffff;

	typedef enum logic [1:0] {
		PS_HEAD     = 2'd0,
		PS_LOW      = 2'd1,
		PS_RUN_HEAD = 2'd2,
		PS_RUN_LOW  = 2'd3
	} parse_state_t;

	// Dictionary configuration as seen by the parser
	typedef struct packed {
		logic [7:0]                       base;
		logic [5:0]                       count;
		logic [DICT_WORDS-1:0][63:0]      bytes;
	} dict_cfg_t;

	// Request from the parser to the emitter
	typedef struct packed {
		logic       emit;
		logic [7:0] value;
		logic [4:0] times;
	} emit_req_t;

	// Parser decision for one character
	typedef struct packed {
		emit_req_t    req;
		parse_state_t next_state;
		logic         load_high;
		logic         load_run;
		logic [4:0]   run_len;
	} parse_act_t;

	// Hex digit value; anything that is not a hex digit counts as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {["0":"9"]}) begin
			v = 4'(c - 8'h30);
		end else if (c inside {["A":"F"]}) begin
			v = 4'(c - 8'h37);
		end else if (c inside {["a":"f"]}) begin
			v = 4'(c - 8'h57);
		end
		return v;
	endfunction

endpackage

/* rtl/rhsd_parse.sv */
// ----------------------------------------------------------------------------
// rhsd_parse
// Classifies one character against the parse state and the dictionary and
// decides what to emit and which state comes next.
// ----------------------------------------------------------------------------
module rhsd_parse (
	input  logic [7:0]                 code_char,
	input  rhsd_pkg::parse_state_t     state,
	input  logic [7:0]                 high_char,
	input  logic [4:0]                 run_len,
	input  rhsd_pkg::dict_cfg_t        cfg,
	output rhsd_pkg::parse_act_t       act
);

	logic [5:0] dict_n;
	logic [8:0] win_end;
	logic       in_dict;
	logic [4:0] dict_idx;
	logic [63:0] dict_word;
	logic [7:0] dict_byte;
	logic       is_mark;
	logic [7:0] hex_byte;

	// Clamp entry count and test the dictionary window in 9 bits
	assign dict_n  = (cfg.count > rhsd_pkg::DICT_MAX) ? rhsd_pkg::DICT_MAX : cfg.count;
	assign win_end = {1'b0, cfg.base} + {3'b000, dict_n};
	assign in_dict = (code_char >= cfg.base) && ({1'b0, code_char} < win_end);

	// Look up the dictionary byte
	assign dict_idx  = 5'(code_char - cfg.base);
	assign dict_word = cfg.bytes[dict_idx[4:3]];
	assign dict_byte = dict_word[{dict_idx[2:0], 3'b000} +: 8];

	assign is_mark  = (code_char >= rhsd_pkg::CHAR_A_LOW) && (code_char <= rhsd_pkg::CHAR_Z_LOW);
	assign hex_byte = {rhsd_pkg::hex_value(high_char), rhsd_pkg::hex_value(code_char)};

	// Decide the action for this character
	always_comb begin
		act.req.emit   = 1'b0;
		act.req.value  = dict_byte;
		act.req.times  = 5'd1;
		act.next_state = rhsd_pkg::PS_HEAD;
		act.load_high  = 1'b0;
		act.load_run   = 1'b0;
		act.run_len    = 5'(code_char - rhsd_pkg::CHAR_A_LOW + 8'd1);
		case (state)
			rhsd_pkg::PS_HEAD: begin
				if (in_dict) begin
					act.req.emit = 1'b1;
				end else if (is_mark) begin
					act.load_run   = 1'b1;
					act.next_state = rhsd_pkg::PS_RUN_HEAD;
				end else begin
					act.load_high  = 1'b1;
					act.next_state = rhsd_pkg::PS_LOW;
				end
			end
			rhsd_pkg::PS_LOW: begin
				act.req.emit  = 1'b1;
				act.req.value = hex_byte;
			end
			rhsd_pkg::PS_RUN_HEAD: begin
				if (in_dict) begin
					act.req.emit  = 1'b1;
					act.req.times = run_len;
				end else begin
					act.load_high  = 1'b1;
					act.next_state = rhsd_pkg::PS_RUN_LOW;
				end
			end
			rhsd_pkg::PS_RUN_LOW: begin
				act.req.emit  = 1'b1;
				act.req.value = hex_byte;
				act.req.times = run_len;
			end
			default: begin
				act.next_state = rhsd_pkg::PS_HEAD;
			end
		endcase
	end

endmodule

/* rtl/rhsd_emit.sv */
// ----------------------------------------------------------------------------
// rhsd_emit
// Run emitter: one shared down counter and saturating byte counter produce
// one output beat per cycle, unless the output stalls, into an output register.
// ----------------------------------------------------------------------------
module rhsd_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  rhsd_pkg::emit_req_t    req,
	input  logic                   load_last,
	input  logic                   clear,
	output logic                   busy,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             out_byte,
	output logic                   run_end,
	output logic [15:0]            out_count
);

	logic        busy_q;
	logic [7:0]  value_q;
	logic [4:0]  rem_q;
	logic        last_q;
	logic [15:0] count_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_end_q;
	logic [15:0] out_count_q;

	logic        step;
	logic        final_beat;
	logic [15:0] count_next;

	// Advance one beat when the output register is free or being drained
	assign step       = busy_q && (!out_valid_q || !out_stall);
	assign final_beat = (rem_q == 5'd1);
	assign count_next = (count_q == rhsd_pkg::COUNT_MAX) ? count_q : count_q + 16'd1;

	// Control state: run sequencer and string byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= 5'd0;
			last_q      <= 1'b0;
			count_q     <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				rem_q  <= req.times;
				last_q <= load_last;
			end else if (step) begin
				rem_q <= rem_q - 5'd1;
				if (final_beat) begin
					busy_q <= 1'b0;
				end
			end
			if (clear) begin
				count_q <= 16'd0;
			end else if (step) begin
				count_q <= (final_beat && last_q) ? 16'd0 : count_next;
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: held value and output register
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= req.value;
		end
		if (step) begin
			out_byte_q  <= value_q;
			run_end_q   <= final_beat;
			out_count_q <= count_next;
		end
	end

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign run_end   = run_end_q;
	assign out_count = out_count_q;

endmodule

/* rtl/rle_hex_string_decoder.sv */
// ----------------------------------------------------------------------------
// rle_hex_string_decoder
// Decodes a run-length, hex and dictionary coded character stream to bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one character per beat with
//   last_char marking the end of a string. Output channel (out_valid /
//   out_stall) carries one decoded byte per beat with run_end on the last
//   byte of a character and the saturating byte count of the string.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wr_data
//   while the block is idle; writes take effect at the next edge.
// Timing:
//   A character is parsed when it is accepted. If it emits N bytes
//   (N = 1..26), the run emitter then produces one byte per cycle unless the
//   output stalls, and holds in_stall high while it runs. The first byte
//   passes through the held value register into the output register.
// Reset clears the parse state, the byte count and the output valid, and
// loads the dictionary registers with their defaults. When the receiver
// stalls, the emitter holds its current byte and the run pauses.
// ----------------------------------------------------------------------------
module rle_hex_string_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  code_char,
	input  logic        last_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic [15:0] out_count
);

	rhsd_pkg::dict_cfg_t    cfg_q;
	rhsd_pkg::parse_state_t state_q;
	logic [7:0]             high_q;
	logic [4:0]             run_q;
	rhsd_pkg::parse_act_t   act;
	logic                   busy;
	logic                   accept;

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base  <= rhsd_pkg::DICT_BASE_RESET;
			cfg_q.count <= 6'd0;
			cfg_q.bytes <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				rhsd_pkg::CFG_DICT_BASE:  cfg_q.base     <= cfg_wr_data[7:0];
				rhsd_pkg::CFG_DICT_COUNT: cfg_q.count    <= cfg_wr_data[5:0];
				rhsd_pkg::CFG_DICT_B0:    cfg_q.bytes[0] <= cfg_wr_data;
				rhsd_pkg::CFG_DICT_B1:    cfg_q.bytes[1] <= cfg_wr_data;
				rhsd_pkg::CFG_DICT_B2:    cfg_q.bytes[2] <= cfg_wr_data;
				rhsd_pkg::CFG_DICT_B3:    cfg_q.bytes[3] <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	rhsd_parse u_parse (
		.code_char (code_char),
		.state     (state_q),
		.high_char (high_q),
		.run_len   (run_q),
		.cfg       (cfg_q),
		.act       (act)
	);

	// Parse state; drop everything pending at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rhsd_pkg::PS_HEAD;
			high_q  <= 8'd0;
			run_q   <= 5'd0;
		end else if (accept) begin
			if (last_char) begin
				state_q <= rhsd_pkg::PS_HEAD;
				high_q  <= 8'd0;
				run_q   <= 5'd0;
			end else begin
				state_q <= act.next_state;
				if (act.load_high) begin
					high_q <= code_char;
				end
				if (act.load_run) begin
					run_q <= act.run_len;
				end
			end
		end
	end

	rhsd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && act.req.emit),
		.req       (act.req),
		.load_last (last_char),
		.clear     (accept && last_char && !act.req.emit),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_end   (run_end),
		.out_count (out_count)
	);

endmodule
